>>> src/slfo_pkg.sv
`timescale 1ns / 1ps

package slfo_pkg;

    // Sample width; the counter and product widths below follow from it.
    parameter int SAMPLE_BITS = 16;
    parameter int SONG_W      = 28;
    parameter int FADE_W      = 24;
    parameter int IDX_W       = 29;
    parameter int CFG_IDX_W   = 2;
    parameter int CFG_DATA_W  = 28;
    parameter int CNT_W       = $clog2(SAMPLE_BITS);
    // Product / partial remainder register: fade-width high part, sample-width low part.
    parameter int PROD_W      = FADE_W + SAMPLE_BITS;

    // Register indexes of the configuration port.
    parameter logic [CFG_IDX_W-1:0] CFG_FADE_ENABLE = 2'd0;
    parameter logic [CFG_IDX_W-1:0] CFG_SONG_LENGTH = 2'd1;
    parameter logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH = 2'd2;

    // Reset values of the configuration registers.
    parameter logic [SONG_W-1:0] SONG_LENGTH_RST = 28'd7497000;
    parameter logic [FADE_W-1:0] FADE_LENGTH_RST = 24'd441000;

    // Step strobes from the sequencer to each channel lane.
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
    } lane_ctrl_t;

endpackage

>>> src/slfo_lane.sv
`timescale 1ns / 1ps

// One channel: sign-magnitude split, bit-serial shift-add multiply by the gain,
// then restoring division by the fade length, one quotient bit per cycle.
module slfo_lane (
    input  logic                                    aclk,
    input  slfo_pkg::lane_ctrl_t                    ctrl,
    input  logic signed [slfo_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [slfo_pkg::FADE_W-1:0]             gain,
    input  logic [slfo_pkg::FADE_W-1:0]             fade,
    output logic signed [slfo_pkg::SAMPLE_BITS-1:0] result
);

    localparam int SB = slfo_pkg::SAMPLE_BITS;
    localparam int FW = slfo_pkg::FADE_W;
    localparam int PW = slfo_pkg::PROD_W;

    logic          neg_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;

    logic [SB-1:0] mag_in;
    logic [FW:0]   mul_sum;
    logic [FW:0]   div_trial;
    logic [FW+1:0] div_diff;
    logic          borrow;
    logic [FW-1:0] rem_new;
    logic [SB-1:0] mag_out;

    assign mag_in = sample[SB-1] ? (~sample + 1'b1) : sample;

    // Multiply step: add gain into the high part when the low bit is set, shift right.
    assign mul_sum = {1'b0, prod_reg[PW-1:SB]} + (prod_reg[0] ? {1'b0, gain} : '0);

    // Divide step: shift in the next dividend bit, subtract the divisor if it fits.
    assign div_trial = {prod_reg[PW-1:SB], prod_reg[SB-1]};
    assign div_diff  = {1'b0, div_trial} - {2'b00, fade};
    assign borrow    = div_diff[FW+1];
    assign rem_new   = borrow ? div_trial[FW-1:0] : div_diff[FW-1:0];

    always_comb begin
        prod_next = prod_reg;
        if (ctrl.load) begin
            prod_next = {{FW{1'b0}}, mag_in};
        end else if (ctrl.mul_step) begin
            prod_next = {mul_sum, prod_reg[SB-1:1]};
        end else if (ctrl.div_step) begin
            prod_next = {rem_new, prod_reg[SB-2:0], ~borrow};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (ctrl.load) begin
            neg_reg <= sample[SB-1];
        end
    end

    // Reapply the sign; truncation toward zero falls out of dividing the magnitude.
    assign mag_out = prod_reg[SB-1:0];
    assign result  = neg_reg ? (~mag_out + 1'b1) : mag_out;

endmodule

>>> src/stereo_linear_fade_out.sv
`timescale 1ns / 1ps
// Flow: a faded beat passes from input accept through the multiply steps, the divide
//   steps and the output load to the result channel; a pass-through, silent or
//   fade-disabled beat goes from accept straight to the output load.
// The input takes no new beat until the last has reached the output register; the
//   bit-serial multiply/divide lanes, one bit per cycle each, do the arithmetic.
// Reset: synchronous active-low aresetn clears index, sequencer, output valid; loads defaults.

module stereo_linear_fade_out (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    // configuration write port
    input  logic                                       cfg_wr_en,
    input  logic [slfo_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [slfo_pkg::CFG_DATA_W-1:0]            cfg_wr_data,
    // input channel
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [slfo_pkg::SAMPLE_BITS-1:0]    s_left_in,
    input  logic signed [slfo_pkg::SAMPLE_BITS-1:0]    s_right_in,
    // result channel
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic signed [slfo_pkg::SAMPLE_BITS-1:0]    m_left_out,
    output logic signed [slfo_pkg::SAMPLE_BITS-1:0]    m_right_out,
    output logic                                       m_finished
);

    localparam int SB    = slfo_pkg::SAMPLE_BITS;
    localparam int FW    = slfo_pkg::FADE_W;
    localparam int SW    = slfo_pkg::SONG_W;
    localparam int IW    = slfo_pkg::IDX_W;
    localparam int CW    = slfo_pkg::CNT_W;
    localparam logic [CW-1:0] CNT_LAST = CW'(SB - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic          fade_enable_reg;
    logic [SW-1:0] song_length_reg;
    logic [FW-1:0] fade_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_enable_reg <= 1'b1;
            song_length_reg <= slfo_pkg::SONG_LENGTH_RST;
            fade_length_reg <= slfo_pkg::FADE_LENGTH_RST;
        end else if (cfg_wr_en) begin
            // Drop writes to indexes past the register list.
            unique case (cfg_index)
                slfo_pkg::CFG_FADE_ENABLE: fade_enable_reg <= cfg_wr_data[0];
                slfo_pkg::CFG_SONG_LENGTH: song_length_reg <= cfg_wr_data[SW-1:0];
                slfo_pkg::CFG_FADE_LENGTH: fade_length_reg <= cfg_wr_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    state_t        state_reg,  state_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic [IW-1:0] idx_reg,    idx_next;
    logic          fin_reg,    fin_next;
    logic [FW-1:0] gain_reg,   gain_next;
    logic          m_valid_reg, m_valid_next;

    logic signed [SB-1:0] m_left_reg,  m_left_next;
    logic signed [SB-1:0] m_right_reg, m_right_next;
    logic                 m_fin_reg,   m_fin_next;

    logic                 in_beat;
    logic                 out_free;
    logic                 out_load;
    logic [IW-1:0]        song_end;
    logic [IW-1:0]        gain_full;
    logic                 past_song;
    logic                 past_end;
    logic                 do_scale;

    slfo_pkg::lane_ctrl_t lane_ctrl;
    logic signed [SB-1:0] left_res;
    logic signed [SB-1:0] right_res;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    // Classify the beat against the current index. The end of the fade fits in the
    // index width, and inside the fade the remaining gain is below the fade length.
    assign song_end  = {1'b0, song_length_reg} + IW'(fade_length_reg);
    assign gain_full = song_end - idx_reg;
    assign past_song = fade_enable_reg && (idx_reg > {1'b0, song_length_reg});
    assign past_end  = past_song && (idx_reg > song_end);
    assign do_scale  = past_song && !past_end;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        gain_next  = gain_reg;
        lane_ctrl  = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    lane_ctrl.load = 1'b1;
                    cnt_next       = CNT_LAST;
                    fin_next       = past_end;
                    gain_next      = gain_full[FW-1:0];
                    // Hold the index at its top value once it gets there.
                    if (idx_reg != {IW{1'b1}}) begin
                        idx_next = idx_reg + IW'(1);
                    end
                    // Pass-through and silent beats skip the lanes' arithmetic.
                    state_next = do_scale ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                lane_ctrl.mul_step = 1'b1;
                if (cnt_reg == '0) begin
                    cnt_next   = CNT_LAST;
                    state_next = ST_DIV;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_DIV: begin
                lane_ctrl.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_OUT: begin
                // Wait here until the output register can take the beat.
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
        cnt_reg  <= cnt_next;
        fin_reg  <= fin_next;
        gain_reg <= gain_next;
    end

    // ---------------------------------------------------------------
    // Channel lanes, stepped together
    // ---------------------------------------------------------------
    slfo_lane u_lane_left (
        .aclk   (aclk),
        .ctrl   (lane_ctrl),
        .sample (s_left_in),
        .gain   (gain_reg),
        .fade   (fade_length_reg),
        .result (left_res)
    );

    slfo_lane u_lane_right (
        .aclk   (aclk),
        .ctrl   (lane_ctrl),
        .sample (s_right_in),
        .gain   (gain_reg),
        .fade   (fade_length_reg),
        .result (right_res)
    );

    // ---------------------------------------------------------------
    // Output register: frees the sequencer while a result beat waits
    // ---------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        m_left_next  = m_left_reg;
        m_right_next = m_right_reg;
        m_fin_next   = m_fin_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            // Silence everything past the end of the fade.
            m_left_next  = fin_reg ? '0 : left_res;
            m_right_next = fin_reg ? '0 : right_res;
            m_fin_next   = fin_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_left_reg  <= m_left_next;
        m_right_reg <= m_right_next;
        m_fin_reg   <= m_fin_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = m_left_reg;
    assign m_right_out = m_right_reg;
    assign m_finished  = m_fin_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_idx_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && idx_reg != {IW{1'b1}}) |=> (idx_reg == $past(idx_reg) + IW'(1)))
        else $error("sample index did not advance on an input beat");

    a_finished_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |-> (m_left_out == '0 && m_right_out == '0))
        else $error("finished beat carries nonzero samples");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid && state_reg == ST_IDLE))
        else $error("result beat not presented after output load");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL || state_reg == ST_DIV) |-> !s_ready)
        else $error("input accepted while lanes are busy");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SB         = slfo_pkg::SAMPLE_BITS;
    localparam int IW         = slfo_pkg::IDX_W;
    localparam int CDW        = slfo_pkg::CFG_DATA_W;
    localparam int FADE_PAD_W = slfo_pkg::CFG_DATA_W - slfo_pkg::FADE_W;

    typedef logic signed [SB-1:0] sample_t;

    // One output beat: the sample pair after the gain, plus the end-of-song flag.
    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    finished;
    } fade_beat_t;

    typedef enum logic {
        ROW_BEAT,
        ROW_WRITE
    } row_kind_t;

    // One row of the directed table: either a register write or an input beat.
    // Where typed is set, want holds the output that the row must produce.
    typedef struct packed {
        row_kind_t                       kind;
        logic [slfo_pkg::CFG_IDX_W-1:0]  reg_sel;
        logic [slfo_pkg::CFG_DATA_W-1:0] reg_value;
        sample_t                         left;
        sample_t                         right;
        logic                            typed;
        fade_beat_t                      want;
    } row_t;

    // Index past the register list; a write to it must be dropped.
    localparam logic [slfo_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam int      FADE_MAX   = (1 << slfo_pkg::FADE_W) - 1;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BEATS  = 600;
    // Leave some slack after the last result.
    localparam int DRAIN_CYCLES  = 40;
    localparam int TIMEOUT_NS    = 2_000_000;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [slfo_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [slfo_pkg::CFG_DATA_W-1:0] cfg_wr_data;
    logic                            s_valid;
    logic                            s_ready;
    sample_t                         s_left_in;
    sample_t                         s_right_in;
    logic                            m_valid;
    logic                            m_ready;
    sample_t                         m_left_out;
    sample_t                         m_right_out;
    logic                            m_finished;

    stereo_linear_fade_out dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_left_in   (s_left_in),
        .s_right_in  (s_right_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out),
        .m_finished  (m_finished)
    );

    // Envelope state as the block should hold it: the three registers and the
    // running pair index, which only reset clears.
    logic                        fade_on;
    logic [slfo_pkg::SONG_W-1:0] song_limit;
    logic [slfo_pkg::FADE_W-1:0] ramp_len;
    logic [IW-1:0]               pair_index;

    // Output beats still owed by the block, oldest first.
    fade_beat_t beats_due [$];

    row_t directed_rows [DIRECTED_ROWS];

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int beats_sent;
    int faded_beats;
    int finished_beats;
    int reg_writes;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL stereo_linear_fade_out");
        $finish;
    end

    // Envelope predictor: gain for the pair at the current index, then advance
    // the index, which sticks at its all-ones value.
    function automatic fade_beat_t step_envelope(sample_t l, sample_t r);
        logic [IW-1:0] song_end;
        longint        gain;
        fade_beat_t    beat;
        song_end = IW'(song_limit) + IW'(ramp_len);
        beat = '{l, r, 1'b0};
        if (fade_on && pair_index > IW'(song_limit)) begin
            if (pair_index > song_end) begin
                // Past the ramp (or any zero-length fade): silence and flag the end.
                beat = '{'0, '0, 1'b1};
                finished_beats++;
            end else begin
                // Exact product, then divide; SystemVerilog truncates toward zero.
                gain = longint'(song_end - pair_index);
                beat.left  = sample_t'((longint'(l) * gain) / longint'(ramp_len));
                beat.right = sample_t'((longint'(r) * gain) / longint'(ramp_len));
                faded_beats++;
            end
        end
        if (pair_index != '1)
            pair_index++;
        return beat;
    endfunction

    // Mirror a register write; unknown indexes change nothing.
    function automatic void set_register(logic [slfo_pkg::CFG_IDX_W-1:0] sel,
                                         logic [slfo_pkg::CFG_DATA_W-1:0] value);
        case (sel)
            slfo_pkg::CFG_FADE_ENABLE: fade_on    = value[0];
            slfo_pkg::CFG_SONG_LENGTH: song_limit = value[slfo_pkg::SONG_W-1:0];
            slfo_pkg::CFG_FADE_LENGTH: ramp_len   = value[slfo_pkg::FADE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic row_t pair_row(sample_t l, sample_t r);
        return '{ROW_BEAT, '0, '0, l, r, 1'b0, '0};
    endfunction

    function automatic row_t known_row(sample_t l, sample_t r,
                                       sample_t want_l, sample_t want_r, logic want_fin);
        return '{ROW_BEAT, '0, '0, l, r, 1'b1, '{want_l, want_r, want_fin}};
    endfunction

    function automatic row_t reg_row(logic [slfo_pkg::CFG_IDX_W-1:0] sel,
                                     logic [slfo_pkg::CFG_DATA_W-1:0] value);
        return '{ROW_WRITE, sel, value, '0, '0, 1'b0, '0};
    endfunction

    // Mostly random samples, with the extremes and values around zero mixed in.
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return sample_t'($urandom_range(0, 2)) - sample_t'(1);
            default: return sample_t'($urandom());
        endcase
    endfunction

    // Drop valid and hold until every owed beat has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (beats_due.size() != 0)
            @(posedge aclk);
    endtask

    // Write one register with the block idle. The enable stays high so that
    // back-to-back writes never lower and raise it in one step; send_pair drops it.
    task automatic write_reg(input logic [slfo_pkg::CFG_IDX_W-1:0] sel,
                             input logic [slfo_pkg::CFG_DATA_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= sel;
        cfg_wr_data <= value;
        @(posedge aclk);
        set_register(sel, value);
        reg_writes++;
    endtask

    // Offer one sample pair, idling first at the current sender rate, and queue
    // its expected output once the beat is taken.
    task automatic send_pair(input sample_t l, input sample_t r,
                             input logic typed, input fade_beat_t want);
        fade_beat_t predicted;
        if (cfg_wr_en)
            cfg_wr_en <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_left_in  <= l;
        s_right_in <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = step_envelope(l, r);
        beats_due.insert(beats_due.size(), typed ? want : predicted);
        beats_sent++;
    endtask

    // Receiver: stall at the current rate, redrawn every cycle.
    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Check each output beat against the oldest owed one.
    always @(posedge aclk) begin
        fade_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (beats_due.size() == 0) begin
                $error("unexpected output beat: left_out %0d right_out %0d finished %0b",
                       m_left_out, m_right_out, m_finished);
                fail_count++;
            end else begin
                want = beats_due.pop_front();
                if (m_left_out !== want.left) begin
                    $error("left_out: expected %0d, got %0d", want.left, m_left_out);
                    fail_count++;
                end
                if (m_right_out !== want.right) begin
                    $error("right_out: expected %0d, got %0d", want.right, m_right_out);
                    fail_count++;
                end
                if (m_finished !== want.finished) begin
                    $error("finished: expected %0b, got %0b", want.finished, m_finished);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic [slfo_pkg::CFG_DATA_W-1:0] reg_value;
        int                              random_beats;

        // Known levels on every input but m_ready before the first edge.
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= slfo_pkg::CFG_FADE_ENABLE;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_left_in   <= '0;
        s_right_in  <= '0;

        fade_on        = 1'b1;
        song_limit     = slfo_pkg::SONG_LENGTH_RST;
        ramp_len       = slfo_pkg::FADE_LENGTH_RST;
        pair_index     = '0;
        fail_count     = 0;
        beats_sent     = 0;
        faded_beats    = 0;
        finished_beats = 0;
        reg_writes     = 0;
        random_beats   = 0;
        send_idle_pct  = 11;
        recv_idle_pct  = 60;

        // Directed beats, index by index from reset (pair index noted for the first ten beats).
        directed_rows = '{
            // Reset lengths put the fade far away: extremes pass untouched (0..2).
            known_row(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0),
            known_row('0, -16'sd1, '0, -16'sd1, 1'b0),
            known_row(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0),
            // Song ends at 4, fade of 4; the upper data bits of the fade write
            // fall outside the register and must be dropped.
            reg_row(slfo_pkg::CFG_SONG_LENGTH, 28'd4),
            reg_row(slfo_pkg::CFG_FADE_LENGTH, 28'hF00_0004),
            pair_row(16'sd12345, -16'sd12345),          // 3: before the song end
            pair_row(SAMPLE_MAX, SAMPLE_MIN),           // 4: at the song end, still passes
            pair_row(SAMPLE_MAX, SAMPLE_MIN),           // 5: gain 3/4
            pair_row(-16'sd1, 16'sd1),                  // 6: gain 2/4, truncates to zero
            pair_row(SAMPLE_MIN, SAMPLE_MAX),           // 7: gain 1/4
            pair_row(SAMPLE_MAX, SAMPLE_MIN),           // 8: gain 0, not yet finished
            known_row(SAMPLE_MAX, SAMPLE_MIN, '0, '0, 1'b1),  // 9: past song plus fade
            // Zero fade length silences everything past the song.
            reg_row(slfo_pkg::CFG_FADE_LENGTH, 28'd0),
            known_row(16'sd100, -16'sd100, '0, '0, 1'b1),
            // Fade disabled: pass forever, no finished flag.
            reg_row(slfo_pkg::CFG_FADE_ENABLE, 28'd0),
            known_row(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0),
            // Largest song and fade lengths.
            reg_row(slfo_pkg::CFG_FADE_ENABLE, 28'd1),
            reg_row(slfo_pkg::CFG_SONG_LENGTH, 28'hFFF_FFFF),
            reg_row(slfo_pkg::CFG_FADE_LENGTH, 28'h0FF_FFFF),
            known_row(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0),
            // Song of zero with the longest fade: widest product and divisor.
            reg_row(slfo_pkg::CFG_SONG_LENGTH, 28'd0),
            pair_row(SAMPLE_MAX, SAMPLE_MIN),
            reg_row(CFG_UNUSED, 28'hFFF_FFFF),
            pair_row(SAMPLE_MIN, SAMPLE_MAX),
            pair_row(16'sd21845, -16'sd21846)
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_value);
            else
                send_pair(directed_rows[i].left, directed_rows[i].right,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases: fresh registers with the block idle, then a burst of
        // beats. Most songs end a few beats ahead with short fades, so bursts
        // run through pass, ramp and silence.
        while (random_beats < RANDOM_BEATS) begin
            if (random_beats < RANDOM_BEATS / 3) begin
                send_idle_pct = 11;
                recv_idle_pct = 60;
            end else if (random_beats < 2 * RANDOM_BEATS / 3) begin
                send_idle_pct = 60;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if ($urandom_range(0, 4) != 0) begin
                // Random upper bits; only bit 0 counts, mostly set.
                reg_value    = CDW'($urandom());
                reg_value[0] = ($urandom_range(0, 7) != 0);
                write_reg(slfo_pkg::CFG_FADE_ENABLE, reg_value);
            end

            if ($urandom_range(0, 5) != 0) begin
                case ($urandom_range(0, 9))
                    0: reg_value = CDW'($urandom());
                    1: reg_value = (pair_index > 8) ?
                                   CDW'(pair_index - $urandom_range(1, 8)) : '0;
                    default: reg_value = CDW'(pair_index + $urandom_range(0, 12));
                endcase
                write_reg(slfo_pkg::CFG_SONG_LENGTH, reg_value);
            end

            if ($urandom_range(0, 5) != 0) begin
                case ($urandom_range(0, 9))
                    0: reg_value = '0;
                    1: reg_value = CDW'($urandom_range(1, FADE_MAX));
                    default: reg_value = CDW'($urandom_range(1, 40));
                endcase
                // Junk above the fade field must be ignored.
                reg_value[CDW-1:slfo_pkg::FADE_W] = FADE_PAD_W'($urandom_range(0, 15));
                write_reg(slfo_pkg::CFG_FADE_LENGTH, reg_value);
            end

            repeat ($urandom_range(10, 60)) begin
                send_pair(pick_sample(), pick_sample(), 1'b0, '0);
                random_beats++;
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d sample pairs around %0d register writes:", beats_sent, reg_writes);
        $display("  %0d inside a fade ramp, %0d silenced past the song end.",
                 faded_beats, finished_beats);
        if (fail_count == 0)
            $display("PASS stereo_linear_fade_out");
        else
            $display("FAIL stereo_linear_fade_out");
        $finish;
    end

endmodule

>>> files.f
src/slfo_pkg.sv
src/slfo_lane.sv
src/stereo_linear_fade_out.sv
tb/sv/tb.sv
